// ===== hdl/rbcs_pkg.sv =====
// Shared types and constants for the RGB brightness/contrast/saturation unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package rbcs_pkg;

    // Pipeline depth: three stages for contrast, three for saturation.
    localparam int NUM_STAGES = 6;

    // Luma weights in Q0.16; they sum to 65536.
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    localparam logic [11:0] GAIN_UNITY = 12'd256;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_CONTRAST   = 2'd1,
        CFG_SATURATION = 2'd2
    } t_cfg_idx;

    // Per-stage load enables, stage 0 nearest the input.
    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Channel triple: index 0 red, 1 green, 2 blue.
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       in_last_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_last_pixel;
    } t_pix_out;

endpackage

`default_nettype wire

// ===== hdl/rbcs_contrast.sv =====
// Brightness and contrast pipeline: offset add, gain multiply, clamp.
// Uses rbcs_pkg; occupies pipeline stages 0..2.
`default_nettype none

module rbcs_contrast
    import rbcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_stage_en   i_en,
    input  wire t_rgb        i_rgb,
    input  wire logic [15:0] i_offset,
    input  wire logic [11:0] i_gain,
    output t_rgb             o_rgb
);

    localparam logic signed [17:0] MID_Q8   = 18'sd32768;
    localparam logic signed [30:0] MID_Q16  = 31'sd8388608;

    t_rgb r_out;

    for (genvar gi = 0; gi < 3; gi++) begin : g_ch
        logic signed [17:0] n_v;
        logic signed [17:0] r_v;
        logic signed [30:0] n_p;
        logic signed [30:0] r_p;
        logic        [7:0]  n_c;

        // Stage 0: Q8.8 value relative to mid level
        always_comb begin
            n_v = $signed({2'b00, i_rgb[gi], 8'h00})
                + $signed({{2{i_offset[15]}}, i_offset}) - MID_Q8;
        end

        // Stage 1: contrast gain, back to Q16 around mid level
        always_comb begin
            n_p = r_v * $signed({1'b0, i_gain}) + MID_Q16;
        end

        // Stage 2: clamp to 0..255 and floor
        always_comb begin
            if (r_p[30]) begin
                n_c = 8'd0;
            end else if (|r_p[29:24]) begin
                n_c = 8'd255;
            end else begin
                n_c = r_p[23:16];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_v <= n_v;
            end
            if (i_en[1]) begin
                r_p <= n_p;
            end
            if (i_en[2]) begin
                r_out[gi] <= n_c;
            end
        end
    end

    assign o_rgb = r_out;

endmodule

`default_nettype wire

// ===== hdl/rbcs_saturation.sv =====
// Saturation pipeline: luma sum, distance-from-gray multiply, clamp.
// Uses rbcs_pkg; occupies pipeline stages 3..5.
`default_nettype none

module rbcs_saturation
    import rbcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_stage_en   i_en,
    input  wire t_rgb        i_rgb,
    input  wire logic [11:0] i_gain,
    output t_rgb             o_rgb
);

    logic [23:0] n_g;
    logic [23:0] r_g;
    logic [23:0] r_ge;
    t_rgb        r_cd;
    t_rgb        r_out;

    // Stage 3: gray level in Q16, no rounding
    always_comb begin
        n_g = LUMA_R * 24'(i_rgb[0]) + LUMA_G * 24'(i_rgb[1]) + LUMA_B * 24'(i_rgb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_g  <= n_g;
            r_cd <= i_rgb;
        end
        if (i_en[4]) begin
            r_ge <= r_g;
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_ch
        logic signed [24:0] n_d;
        logic signed [37:0] n_m;
        logic signed [37:0] r_m;
        logic signed [38:0] n_q;
        logic        [7:0]  n_c;

        // Stage 4: distance from gray times saturation gain
        always_comb begin
            n_d = $signed({1'b0, r_cd[gi], 16'h0000}) - $signed({1'b0, r_g});
            n_m = n_d * $signed({1'b0, i_gain});
        end

        // Stage 5: add gray back in Q24, clamp and floor
        always_comb begin
            n_q = $signed({7'b0, r_ge, 8'h00}) + r_m;
            if (n_q[38]) begin
                n_c = 8'd0;
            end else if (|n_q[37:32]) begin
                n_c = 8'd255;
            end else begin
                n_c = n_q[31:24];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[4]) begin
                r_m <= n_m;
            end
            if (i_en[5]) begin
                r_out[gi] <= n_c;
            end
        end
    end

    assign o_rgb = r_out;

endmodule

`default_nettype wire

// ===== hdl/rgb_brightness_contrast_saturation_unit.sv =====
// RGB brightness/contrast/saturation adjuster. Takes one pixel per clock when
// the output is not stalled and returns each result after the six register
// stages (offset add, contrast multiply, clamp, luma sum, saturation multiply,
// clamp). A stall on the output freezes only stages that hold data, so bubbles
// are squeezed out.
// Configuration writes take effect at once and are meant for idle periods.
// Unity gains and zero offset reduce to identity without a separate bypass.
// Depends on rbcs_pkg, rbcs_contrast and rbcs_saturation.
`default_nettype none

module rgb_brightness_contrast_saturation_unit
    import rbcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_pix_in     i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_pix_out         o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0]           r_offset;
    logic [11:0]           r_contrast;
    logic [11:0]           r_saturation;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] r_last;
    t_stage_en             w_en;
    t_rgb                  w_in_rgb;
    t_rgb                  w_s1_rgb;
    t_rgb                  w_s2_rgb;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= 16'd0;
            r_contrast   <= GAIN_UNITY;
            r_saturation <= GAIN_UNITY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BRIGHTNESS: r_offset     <= i_cfg_data;
                CFG_CONTRAST:   r_contrast   <= i_cfg_data[11:0];
                CFG_SATURATION: r_saturation <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_last[0] <= i_data.in_last_pixel;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign w_in_rgb[0] = i_data.in_red;
    assign w_in_rgb[1] = i_data.in_green;
    assign w_in_rgb[2] = i_data.in_blue;

    rbcs_contrast u_contrast (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_rgb    (w_in_rgb),
        .i_offset (r_offset),
        .i_gain   (r_contrast),
        .o_rgb    (w_s1_rgb)
    );

    rbcs_saturation u_saturation (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rgb  (w_s1_rgb),
        .i_gain (r_saturation),
        .o_rgb  (w_s2_rgb)
    );

    assign o_ready               = w_en[0];
    assign o_valid               = r_vld[NUM_STAGES-1];
    assign o_data.out_red        = w_s2_rgb[0];
    assign o_data.out_green      = w_s2_rgb[1];
    assign o_data.out_blue       = w_s2_rgb[2];
    assign o_data.out_last_pixel = r_last[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/rbcs_checker.sv =====
// Port-level assertions for the RGB brightness/contrast/saturation unit.
// Uses rbcs_pkg; bound to rgb_brightness_contrast_saturation_unit below.
`default_nettype none

module rbcs_checker
    import rbcs_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_ready,
    input wire logic     o_valid,
    input wire logic     i_ready,
    input wire t_pix_out o_data
);

    // A result not taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("output payload changed while stalled");

    // Empty output stage means the whole pipe can move
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output stage");

    // Downstream acceptance always propagates to the input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input not ready while output is drained");

endmodule

bind rgb_brightness_contrast_saturation_unit rbcs_checker u_rbcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire
